// ===== src/irl_pkg.sv =====
// Shared types and constants for the in-flight request limiter.
`timescale 1ns / 1ps
`default_nettype none

package irl_pkg;

	localparam int KIND_W  = 2;
	localparam int CFG_W   = 5;
	localparam int SLOTS_W = 5;

	localparam logic [KIND_W-1:0] KIND_REQUESTED = 2'd0;
	localparam logic [KIND_W-1:0] KIND_DELIVERED = 2'd1;
	localparam logic [KIND_W-1:0] KIND_DROPPED   = 2'd2;

	localparam logic CMD_REQUEST = 1'b0;
	localparam logic CMD_DELIVER = 1'b1;

	localparam logic [CFG_W-1:0] SLOT_LIMIT_RESET = 5'd16;

	typedef struct packed {
		logic clear;
		logic push;
		logic pop;
	} fifo_ctl_t;

	typedef struct packed {
		logic empty;
		logic full;
	} fifo_stat_t;

endpackage

`default_nettype wire

// ===== src/irl_pending_fifo.sv =====
// Pending key queue: circular buffer in a memory with a registered head read.
`timescale 1ns / 1ps
`default_nettype none

module irl_pending_fifo
	import irl_pkg::*;
#(
	parameter int PENDING_DEPTH = 64,
	parameter int KEY_BITS      = 48
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire fifo_ctl_t           ctl,
	input  wire logic [KEY_BITS-1:0] wr_data,
	output fifo_stat_t               stat,
	output logic      [KEY_BITS-1:0] rd_data
);

	localparam int PTR_W = $clog2(PENDING_DEPTH);
	localparam int CNT_W = $clog2(PENDING_DEPTH + 1);

	logic [KEY_BITS-1:0] mem [PENDING_DEPTH];
	logic [PTR_W-1:0]    head_q;
	logic [PTR_W-1:0]    tail_q;
	logic [CNT_W-1:0]    count_q;
	logic [KEY_BITS-1:0] rd_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else if (ctl.clear) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
		end else begin
			if (ctl.push) begin
				tail_q <= (tail_q == PTR_W'(PENDING_DEPTH - 1)) ? '0 : tail_q + 1'b1;
			end
			if (ctl.pop) begin
				head_q <= (head_q == PTR_W'(PENDING_DEPTH - 1)) ? '0 : head_q + 1'b1;
			end
			if (ctl.push && !ctl.pop) begin
				count_q <= count_q + 1'b1;
			end else if (ctl.pop && !ctl.push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// The head entry is read every cycle; a pop sees the entry captured before it.
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			mem[tail_q] <= wr_data;
		end
		rd_data_q <= mem[head_q];
	end

	assign rd_data    = rd_data_q;
	assign stat.empty = (count_q == '0);
	assign stat.full  = (count_q == CNT_W'(PENDING_DEPTH));

endmodule

`default_nettype wire

// ===== src/inflight_request_limiter.sv =====
// An item passes through the slot scan and a decide state, and any result through an emit
// state into the output register; a delivery that pops a queued key then runs pop, load and a second scan.
// A new item is taken only in the idle state, once the previous item is through; the slot scan
// reads one key a cycle through the single read port of the slot store into one comparator.
// Reset (arst_n, asynchronous, active low) clears slot valid bits, counts, queue
// pointers and the output valid bit; slot_limit returns to 16; key storage is not cleared.
`timescale 1ns / 1ps
`default_nettype none

module inflight_request_limiter
	import irl_pkg::*;
#(
	parameter int SLOT_CAPACITY = 16,
	parameter int PENDING_DEPTH = 64,
	parameter int KEY_BITS      = 48
) (
	input  wire logic                                       clk,
	input  wire logic                                       arst_n,
	// Configuration write channel: slot_limit.
	input  wire logic                                       cfg_valid,
	output logic                                            cfg_ready,
	input  wire logic [CFG_W-1:0]                           cfg_data,
	// Input stream.
	input  wire logic                                       s_tvalid,
	output logic                                            s_tready,
	input  wire logic [((KEY_BITS + 7) / 8) * 8 - 1:0]      s_tdata,  // tile_key
	input  wire logic [1:0]                                 s_tuser,  // cmd, batch_start
	// Result stream.
	output logic                                            m_tvalid,
	input  wire logic                                       m_tready,
	output logic [((KEY_BITS + SLOTS_W + 7) / 8) * 8 - 1:0] m_tdata,  // event_key, slots_in_use
	output logic [KIND_W-1:0]                               m_tuser,  // event_kind
	output logic                                            m_tlast   // last_of_run
);

	localparam int OUT_W  = ((KEY_BITS + SLOTS_W + 7) / 8) * 8;
	localparam int SLOT_W = (SLOT_CAPACITY > 1) ? $clog2(SLOT_CAPACITY) : 1;
	localparam int CNT_W  = $clog2(SLOT_CAPACITY + 1);
	localparam int LIM_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

	localparam logic [2:0] ST_IDLE   = 3'd0;
	localparam logic [2:0] ST_SCAN   = 3'd1;
	localparam logic [2:0] ST_DECIDE = 3'd2;
	localparam logic [2:0] ST_EMIT   = 3'd3;
	localparam logic [2:0] ST_POP    = 3'd4;
	localparam logic [2:0] ST_LOAD   = 3'd5;

	logic [2:0]               state_q;
	logic [CFG_W-1:0]         slot_limit_q;
	logic                     cmd_q;
	logic                     phase_q;
	logic [KEY_BITS-1:0]      key_q;

	logic [KEY_BITS-1:0]      flight_keys [SLOT_CAPACITY];
	logic [SLOT_CAPACITY-1:0] flight_valid_q;
	logic [CNT_W-1:0]         flight_count_q;

	logic [CNT_W-1:0]         scan_cnt_q;
	logic                     cmp_vld_s1;
	logic [SLOT_W-1:0]        cmp_idx_s1;
	logic [KEY_BITS-1:0]      flight_rd_s1;
	logic                     found_q;
	logic [SLOT_W-1:0]        found_idx_q;
	logic                     free_found_q;
	logic [SLOT_W-1:0]        free_idx_q;

	logic [KIND_W-1:0]        res_kind_q;
	logic [KEY_BITS-1:0]      res_key_q;
	logic                     res_last_q;

	logic                     m_tvalid_q;
	logic [KIND_W-1:0]        m_kind_q;
	logic [KEY_BITS-1:0]      m_key_q;
	logic [SLOTS_W-1:0]       m_slots_q;
	logic                     m_last_q;

	fifo_ctl_t                fifo_ctl;
	fifo_stat_t               fifo_stat;
	logic [KEY_BITS-1:0]      fifo_rd_data;

	logic                     in_accept;
	logic                     scan_issue;
	logic                     scan_done;
	logic                     cmp_hit;
	logic                     cmp_free;
	logic [LIM_W-1:0]         lim_raw;
	logic [LIM_W-1:0]         lim_eff;
	logic                     at_limit;
	logic                     is_req;
	logic                     is_dlv;
	logic                     do_insert;
	logic                     do_push;
	logic                     do_free;
	logic                     out_free;
	logic                     emit_fire;
	logic [CNT_W+SLOTS_W-1:0] count_ext;

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == ST_IDLE);
	assign in_accept = s_tvalid && s_tready;

	// One slot is read per cycle; the compare happens in the following cycle on the registered word.
	assign scan_issue = (state_q == ST_SCAN) && (scan_cnt_q != CNT_W'(SLOT_CAPACITY));
	assign scan_done  = (state_q == ST_SCAN) && !scan_issue && !cmp_vld_s1;
	assign cmp_hit    = cmp_vld_s1 && flight_valid_q[cmp_idx_s1] && (flight_rd_s1 == key_q);
	assign cmp_free   = cmp_vld_s1 && !flight_valid_q[cmp_idx_s1];

	// A limit of zero acts as one, and the limit never exceeds the slot capacity.
	always_comb begin
		lim_raw = LIM_W'(slot_limit_q);
		if (lim_raw == '0) begin
			lim_eff = LIM_W'(1);
		end else if (lim_raw > LIM_W'(SLOT_CAPACITY)) begin
			lim_eff = LIM_W'(SLOT_CAPACITY);
		end else begin
			lim_eff = lim_raw;
		end
	end

	assign at_limit  = (LIM_W'(flight_count_q) >= lim_eff);
	assign is_req    = !phase_q && (cmd_q == CMD_REQUEST);
	assign is_dlv    = !phase_q && (cmd_q == CMD_DELIVER);
	assign do_insert = (state_q == ST_DECIDE) && !found_q && free_found_q
		&& (phase_q || (is_req && !at_limit));
	assign do_push   = (state_q == ST_DECIDE) && is_req && !found_q && at_limit
		&& !fifo_stat.full;
	assign do_free   = (state_q == ST_DECIDE) && is_dlv && found_q;

	assign fifo_ctl.clear = in_accept && (s_tuser[0] == CMD_REQUEST) && s_tuser[1];
	assign fifo_ctl.push  = do_push;
	assign fifo_ctl.pop   = (state_q == ST_POP);

	irl_pending_fifo #(
		.PENDING_DEPTH(PENDING_DEPTH),
		.KEY_BITS     (KEY_BITS)
	) u_pending (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (fifo_ctl),
		.wr_data(key_q),
		.stat   (fifo_stat),
		.rd_data(fifo_rd_data)
	);

	always_ff @(posedge clk) begin
		if (do_insert) begin
			flight_keys[free_idx_q] <= key_q;
		end
		flight_rd_s1 <= flight_keys[scan_cnt_q[SLOT_W-1:0]];
		cmp_idx_s1   <= scan_cnt_q[SLOT_W-1:0];
	end

	assign out_free  = !m_tvalid_q || m_tready;
	assign emit_fire = (state_q == ST_EMIT) && out_free;
	assign count_ext = {{SLOTS_W{1'b0}}, flight_count_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			slot_limit_q   <= SLOT_LIMIT_RESET;
			flight_valid_q <= '0;
			flight_count_q <= '0;
			scan_cnt_q     <= '0;
			cmp_vld_s1     <= 1'b0;
			found_q        <= 1'b0;
			free_found_q   <= 1'b0;
			phase_q        <= 1'b0;
			m_tvalid_q     <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				slot_limit_q <= cfg_data;
			end
			if (emit_fire) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			cmp_vld_s1 <= scan_issue;

			case (state_q)
				ST_IDLE: begin
					if (in_accept) begin
						phase_q      <= 1'b0;
						scan_cnt_q   <= '0;
						found_q      <= 1'b0;
						free_found_q <= 1'b0;
						state_q      <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_issue) begin
						scan_cnt_q <= scan_cnt_q + 1'b1;
					end
					if (cmp_hit && !found_q) begin
						found_q     <= 1'b1;
						found_idx_q <= cmp_idx_s1;
					end
					if (cmp_free && !free_found_q) begin
						free_found_q <= 1'b1;
						free_idx_q   <= cmp_idx_s1;
					end
					if (scan_done) begin
						state_q <= ST_DECIDE;
					end
				end
				ST_DECIDE: begin
					res_key_q <= key_q;
					if (do_insert) begin
						flight_valid_q[free_idx_q] <= 1'b1;
						flight_count_q             <= flight_count_q + 1'b1;
					end
					if (do_free) begin
						flight_valid_q[found_idx_q] <= 1'b0;
						flight_count_q              <= flight_count_q - 1'b1;
					end
					if (is_dlv) begin
						res_kind_q <= KIND_DELIVERED;
						res_last_q <= fifo_stat.empty;
						state_q    <= ST_EMIT;
					end else if (phase_q) begin
						// A popped key already in flight is reported without a second slot.
						res_kind_q <= (found_q || free_found_q) ? KIND_REQUESTED : KIND_DROPPED;
						res_last_q <= 1'b1;
						state_q    <= ST_EMIT;
					end else if (found_q) begin
						state_q <= ST_IDLE;
					end else if (at_limit) begin
						res_kind_q <= KIND_DROPPED;
						res_last_q <= 1'b1;
						state_q    <= fifo_stat.full ? ST_EMIT : ST_IDLE;
					end else begin
						res_kind_q <= free_found_q ? KIND_REQUESTED : KIND_DROPPED;
						res_last_q <= 1'b1;
						state_q    <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (emit_fire) begin
						m_kind_q   <= res_kind_q;
						m_key_q    <= res_key_q;
						m_slots_q  <= count_ext[SLOTS_W-1:0];
						m_last_q   <= res_last_q;
						state_q    <= res_last_q ? ST_IDLE : ST_POP;
					end
				end
				ST_POP: begin
					state_q <= ST_LOAD;
				end
				ST_LOAD: begin
					phase_q      <= 1'b1;
					scan_cnt_q   <= '0;
					found_q      <= 1'b0;
					free_found_q <= 1'b0;
					state_q      <= ST_SCAN;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// The key register takes the accepted beat, or the queue head before its scan.
	always_ff @(posedge clk) begin
		if (in_accept) begin
			cmd_q <= s_tuser[0];
			key_q <= s_tdata[KEY_BITS-1:0];
		end else if (state_q == ST_LOAD) begin
			key_q <= fifo_rd_data;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = OUT_W'({m_slots_q, m_key_q});
	assign m_tuser  = m_kind_q;
	assign m_tlast  = m_last_q;

	a_count_matches_valid: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(flight_valid_q) == int'(flight_count_q))
		else $error("slot count disagrees with valid bits");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		int'(flight_count_q) <= SLOT_CAPACITY)
		else $error("slot count above capacity");

	a_scan_complete: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DECIDE) |-> (!cmp_vld_s1 && scan_cnt_q == CNT_W'(SLOT_CAPACITY)))
		else $error("decision taken before the slot scan finished");

	a_insert_needs_free: assert property (@(posedge clk) disable iff (!arst_n)
		do_insert |-> !flight_valid_q[free_idx_q])
		else $error("insert into an occupied slot");

endmodule

`default_nettype wire

// ===== dv/tb_inflight_request_limiter.sv =====
// Self-checking testbench for the in-flight request limiter with a scoreboard predictor.
`timescale 1ns / 1ps

module tb_inflight_request_limiter;
	import irl_pkg::*;

	localparam int SLOTS  = 16;
	localparam int QDEPTH = 64;
	localparam int KEYW   = 48;
	localparam int POOL_N = 20;
	localparam logic [KEYW-1:0] KEY_ONES = {KEYW{1'b1}};

	typedef struct packed {
		logic            cmd;
		logic            batch;
		logic [KEYW-1:0] key;
	} tile_cmd_t;

	typedef struct packed {
		logic [KIND_W-1:0]  kind;
		logic [KEYW-1:0]    key;
		logic [SLOTS_W-1:0] slots;
		logic               last;
	} fetch_event_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_W-1:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [KEYW-1:0] s_tdata = '0;  // tile_key
	logic [1:0] s_tuser = '0;       // cmd, batch_start
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [55:0] m_tdata;           // event_key, slots_in_use
	logic [KIND_W-1:0] m_tuser;     // event_kind
	logic m_tlast;                  // last_of_run

	inflight_request_limiter #(
		.SLOT_CAPACITY(SLOTS),
		.PENDING_DEPTH(QDEPTH),
		.KEY_BITS(KEYW)
	) u_dut (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data(cfg_data),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.m_tlast(m_tlast)
	);

	tile_cmd_t    tile_cmds_q[$];
	fetch_event_t fetch_events_q[$];
	int           mismatches = 0;
	bit           no_idle = 1'b0;
	int           items_added = 0;
	int           items_taken = 0;

	// Predictor state: the in-flight set, the waiting queue and the limit register.
	logic [KEYW-1:0]  flight_key[SLOTS];
	bit               flight_vld[SLOTS];
	int               flight_cnt = 0;
	logic [KEYW-1:0]  wait_key[QDEPTH];
	int               wait_head = 0;
	int               wait_cnt = 0;
	logic [CFG_W-1:0] tb_limit = SLOT_LIMIT_RESET;

	initial begin
		forever #2 clk = ~clk;
	end

	initial begin
		#20_000_000;
		$display("tb: failure");
		$finish;
	end

	function automatic int idle_len();
		int r;
		r = $urandom_range(99);
		if (no_idle || r < 60)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(20, 4);
		return $urandom_range(80, 30);
	endfunction

	function automatic int find_flight(input logic [KEYW-1:0] key);
		for (int i = 0; i < SLOTS; i++)
			if (flight_vld[i] && flight_key[i] == key)
				return i;
		return -1;
	endfunction

	function automatic bit claim_slot(input logic [KEYW-1:0] key);
		for (int i = 0; i < SLOTS; i++) begin
			if (!flight_vld[i]) begin
				flight_vld[i] = 1'b1;
				flight_key[i] = key;
				flight_cnt++;
				return 1'b1;
			end
		end
		return 1'b0;
	endfunction

	function automatic void note_event(input logic [KIND_W-1:0] kind, input logic [KEYW-1:0] key);
		fetch_event_t ev;
		ev.kind  = kind;
		ev.key   = key;
		ev.slots = SLOTS_W'(flight_cnt);
		ev.last  = 1'b0;
		fetch_events_q = {fetch_events_q, ev};
	endfunction

	function automatic void predict_events(input tile_cmd_t item);
		int n0;
		int eff_limit;
		int hit;
		logic [KEYW-1:0] head;
		fetch_event_t ev;
		n0 = fetch_events_q.size();
		eff_limit = (tb_limit == 0) ? 1 : ((tb_limit > SLOTS) ? SLOTS : int'(tb_limit));
		if (item.cmd == CMD_REQUEST) begin
			if (item.batch) begin
				wait_head = 0;
				wait_cnt = 0;
			end
			if (find_flight(item.key) < 0) begin
				if (flight_cnt >= eff_limit) begin
					if (wait_cnt >= QDEPTH) begin
						note_event(KIND_DROPPED, item.key);
					end else begin
						wait_key[(wait_head + wait_cnt) % QDEPTH] = item.key;
						wait_cnt++;
					end
				end else if (claim_slot(item.key)) begin
					note_event(KIND_REQUESTED, item.key);
				end else begin
					note_event(KIND_DROPPED, item.key);
				end
			end
		end else begin
			hit = find_flight(item.key);
			if (hit >= 0) begin
				flight_vld[hit] = 1'b0;
				flight_cnt--;
			end
			note_event(KIND_DELIVERED, item.key);
			if (wait_cnt > 0) begin
				head = wait_key[wait_head];
				wait_head = (wait_head + 1) % QDEPTH;
				wait_cnt--;
				// A queued key that is already in flight is reported without a second slot.
				if (find_flight(head) >= 0 || claim_slot(head))
					note_event(KIND_REQUESTED, head);
				else
					note_event(KIND_DROPPED, head);
			end
		end
		if (fetch_events_q.size() > n0) begin
			ev = fetch_events_q.pop_back();
			ev.last = 1'b1;
			fetch_events_q = {fetch_events_q, ev};
		end
	endfunction

	// Driver: a new beat is presented once the previous one has been taken.
	int        src_gap = 0;
	tile_cmd_t src_item;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
			src_gap <= 0;
		end else if (!s_tvalid || s_tready) begin
			if (src_gap != 0) begin
				src_gap <= src_gap - 1;
				s_tvalid <= 1'b0;
			end else if (tile_cmds_q.size() != 0) begin
				src_item = tile_cmds_q.pop_front();
				s_tvalid <= 1'b1;
				s_tdata <= src_item.key;
				s_tuser <= {src_item.batch, src_item.cmd};
				src_gap <= idle_len();
			end else begin
				s_tvalid <= 1'b0;
			end
		end
	end

	int sink_hold = 0;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
			sink_hold <= 0;
		end else if (sink_hold != 0) begin
			sink_hold <= sink_hold - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
			sink_hold <= idle_len();
		end
	end

	// Monitor: predicts on every accepted input beat and checks every result beat.
	fetch_event_t exp_ev;

	always @(posedge clk) begin
		if (arst_n) begin
			if (cfg_valid && cfg_ready)
				tb_limit <= cfg_data;
			if (s_tvalid && s_tready) begin
				items_taken++;
				predict_events(tile_cmd_t'({s_tuser[0], s_tuser[1], s_tdata}));
			end
			if (m_tvalid && m_tready) begin
				if (fetch_events_q.size() == 0) begin
					mismatches++;
					$display("%0t: unexpected result kind %0d key %h slots %0d last %0b",
						$time, m_tuser, m_tdata[KEYW-1:0], m_tdata[KEYW+SLOTS_W-1:KEYW], m_tlast);
				end else begin
					exp_ev = fetch_events_q.pop_front();
					if (m_tuser !== exp_ev.kind) begin
						mismatches++;
						$display("%0t: event_kind expected %0d actual %0d", $time, exp_ev.kind, m_tuser);
					end
					if (m_tdata[KEYW-1:0] !== exp_ev.key) begin
						mismatches++;
						$display("%0t: event_key expected %h actual %h", $time, exp_ev.key,
							m_tdata[KEYW-1:0]);
					end
					if (m_tdata[KEYW+SLOTS_W-1:KEYW] !== exp_ev.slots) begin
						mismatches++;
						$display("%0t: slots_in_use expected %0d actual %0d", $time, exp_ev.slots,
							m_tdata[KEYW+SLOTS_W-1:KEYW]);
					end
					if (m_tlast !== exp_ev.last) begin
						mismatches++;
						$display("%0t: last_of_run expected %0b actual %0b", $time, exp_ev.last,
							m_tlast);
					end
				end
			end
		end
	end

	task automatic add_item(input logic cmd, input logic batch, input logic [KEYW-1:0] key);
		tile_cmd_t item;
		item.cmd = cmd;
		item.batch = batch;
		item.key = key;
		tile_cmds_q = {tile_cmds_q, item};
		items_added++;
	endtask

	task automatic write_limit(input logic [CFG_W-1:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= value;
		do
			@(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// Queued requests give no result, so the block may still be busy after the last
	// expected beat; the extra wait covers the longest item time.
	task automatic settle();
		while (items_taken != items_added || fetch_events_q.size() != 0)
			@(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	initial begin
		logic [KEYW-1:0] key_pool[POOL_N];
		int phase_limit[8] = '{0, 16, 1, 31, -1, 4, 2, 16};
		int deliver_pct[8] = '{45, 40, 15, 45, 40, 45, 50, 40};
		int batch_pct[8]   = '{5, 5, 0, 5, 3, 5, 5, 3};
		logic cmd;
		logic batch;
		logic [KEYW-1:0] key;

		for (int i = 0; i < SLOTS; i++)
			flight_vld[i] = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Reset limit: skip of a key in flight, delivery of present and absent keys.
		add_item(CMD_REQUEST, 1'b1, '0);
		add_item(CMD_REQUEST, 1'b0, KEY_ONES);
		add_item(CMD_REQUEST, 1'b0, '0);
		add_item(CMD_DELIVER, 1'b1, '0);
		add_item(CMD_DELIVER, 1'b0, '0);
		add_item(CMD_DELIVER, 1'b0, KEY_ONES);
		settle();

		// Limit of one: queueing, duplicate queue entries, a popped key already in
		// flight, growth past the limit through pops, and batch clears.
		write_limit(5'd1);
		add_item(CMD_REQUEST, 1'b0, 48'h0000_0000_00A1);
		add_item(CMD_REQUEST, 1'b0, 48'h0000_0000_00B2);
		add_item(CMD_REQUEST, 1'b0, 48'h0000_0000_00B2);
		add_item(CMD_REQUEST, 1'b0, 48'h0000_0000_00C3);
		add_item(CMD_DELIVER, 1'b0, 48'h0000_0000_00A1);
		add_item(CMD_DELIVER, 1'b0, 48'h5555_5555_5555);
		add_item(CMD_DELIVER, 1'b0, 48'hAAAA_AAAA_AAAA);
		add_item(CMD_REQUEST, 1'b1, 48'h0000_0000_00D4);
		add_item(CMD_REQUEST, 1'b0, 48'h0000_0000_00E5);
		add_item(CMD_REQUEST, 1'b1, 48'h8000_0000_00F6);
		add_item(CMD_DELIVER, 1'b0, 48'h0000_0000_00B2);
		add_item(CMD_DELIVER, 1'b0, 48'h0000_0000_00C3);
		add_item(CMD_DELIVER, 1'b0, 48'h8000_0000_00F6);
		add_item(CMD_DELIVER, 1'b0, 48'h0000_0000_00A1);
		settle();

		for (int ph = 0; ph < 8; ph++) begin
			if (phase_limit[ph] < 0)
				write_limit(CFG_W'($urandom_range(31)));
			else
				write_limit(CFG_W'(phase_limit[ph]));
			no_idle = (ph % 3 == 1);
			key_pool[0] = '0;
			key_pool[1] = KEY_ONES;
			for (int i = 2; i < POOL_N; i++)
				key_pool[i] = KEYW'({$urandom, $urandom});
			for (int n = 0; n < 225; n++) begin
				cmd = ($urandom_range(99) < deliver_pct[ph]) ? CMD_DELIVER : CMD_REQUEST;
				if (cmd == CMD_DELIVER)
					batch = 1'($urandom_range(1));
				else
					batch = ($urandom_range(99) < batch_pct[ph]);
				if ($urandom_range(9) == 0)
					key = KEYW'({$urandom, $urandom});
				else
					key = key_pool[$urandom_range(POOL_N - 1)];
				add_item(cmd, batch, key);
			end
			settle();
		end

		if (mismatches == 0)
			$display("tb: success");
		else
			$display("tb: failure");
		$finish;
	end

endmodule
